[hdl/bqf_pkg.sv]
// Shared types, constants and the per-form step sequence of the biquad section.
package bqf_pkg;

    localparam int STATE_BITS      = 32;
    localparam int STATE_FRAC      = 24;
    localparam int SUM_BITS        = 40;
    localparam int DIGIT_BITS      = 4;
    localparam int PC_BITS         = 5;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int FORM_BITS       = 2;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_A0   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_A1   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_A2   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_B1   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_B2   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FORM = 3'd5;

    typedef enum logic [FORM_BITS-1:0] {
        FORM_DIRECT     = 2'd0,
        FORM_CANONICAL  = 2'd1,
        FORM_TDIRECT    = 2'd2,
        FORM_TCANONICAL = 2'd3
    } form_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_RND,
        S_ACC
    } state_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_ADD,
        OP_MAC,
        OP_STORE,
        OP_END
    } op_t;

    // operand source, also the destination of a store
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_X,
        SRC_W,
        SRC_Y,
        SRC_D1,
        SRC_D2,
        SRC_D3,
        SRC_D4
    } src_t;

    typedef enum logic [2:0] {
        CF_A0,
        CF_A1,
        CF_A2,
        CF_B1,
        CF_B2
    } coef_t;

    typedef struct packed {
        op_t   op;
        src_t  src;
        coef_t cf;
        logic  neg;
    } uop_t;

    function automatic uop_t mk(op_t op, src_t src, coef_t cf, logic neg);
        uop_t u;
        u.op  = op;
        u.src = src;
        u.cf  = cf;
        u.neg = neg;
        return u;
    endfunction

    function automatic uop_t ld(src_t src);
        return mk(OP_LOAD, src, CF_A0, 1'b0);
    endfunction

    function automatic uop_t st(src_t dst);
        return mk(OP_STORE, dst, CF_A0, 1'b0);
    endfunction

    // Step sequence for one item; every sum is built in the accumulator and
    // saturated to Q8.24 on store. Old delay values are read before overwritten.
    function automatic uop_t prog_step(form_t form, logic [PC_BITS-1:0] pc);
        uop_t u;
        u = mk(OP_END, SRC_ZERO, CF_A0, 1'b0);
        case (form)
            FORM_DIRECT:
            begin
                case (pc)
                    5'd0:    u = ld(SRC_ZERO);
                    5'd1:    u = mk(OP_MAC, SRC_X, CF_A0, 1'b0);
                    5'd2:    u = mk(OP_MAC, SRC_D1, CF_A1, 1'b0);
                    5'd3:    u = mk(OP_MAC, SRC_D2, CF_A2, 1'b0);
                    5'd4:    u = mk(OP_MAC, SRC_D3, CF_B1, 1'b1);
                    5'd5:    u = mk(OP_MAC, SRC_D4, CF_B2, 1'b1);
                    5'd6:    u = st(SRC_Y);
                    5'd7:    u = ld(SRC_D1);
                    5'd8:    u = st(SRC_D2);
                    5'd9:    u = ld(SRC_X);
                    5'd10:   u = st(SRC_D1);
                    5'd11:   u = ld(SRC_D3);
                    5'd12:   u = st(SRC_D4);
                    5'd13:   u = ld(SRC_Y);
                    5'd14:   u = st(SRC_D3);
                    default: u = mk(OP_END, SRC_ZERO, CF_A0, 1'b0);
                endcase
            end
            FORM_CANONICAL:
            begin
                case (pc)
                    5'd0:    u = ld(SRC_X);
                    5'd1:    u = mk(OP_MAC, SRC_D1, CF_B1, 1'b1);
                    5'd2:    u = mk(OP_MAC, SRC_D2, CF_B2, 1'b1);
                    5'd3:    u = st(SRC_W);
                    5'd4:    u = ld(SRC_ZERO);
                    5'd5:    u = mk(OP_MAC, SRC_W, CF_A0, 1'b0);
                    5'd6:    u = mk(OP_MAC, SRC_D1, CF_A1, 1'b0);
                    5'd7:    u = mk(OP_MAC, SRC_D2, CF_A2, 1'b0);
                    5'd8:    u = st(SRC_Y);
                    5'd9:    u = ld(SRC_D1);
                    5'd10:   u = st(SRC_D2);
                    5'd11:   u = ld(SRC_W);
                    5'd12:   u = st(SRC_D1);
                    default: u = mk(OP_END, SRC_ZERO, CF_A0, 1'b0);
                endcase
            end
            FORM_TDIRECT:
            begin
                case (pc)
                    5'd0:    u = ld(SRC_X);
                    5'd1:    u = mk(OP_ADD, SRC_D3, CF_A0, 1'b0);
                    5'd2:    u = st(SRC_W);
                    5'd3:    u = ld(SRC_D1);
                    5'd4:    u = mk(OP_MAC, SRC_W, CF_A0, 1'b0);
                    5'd5:    u = st(SRC_Y);
                    5'd6:    u = ld(SRC_D4);
                    5'd7:    u = mk(OP_MAC, SRC_W, CF_B1, 1'b1);
                    5'd8:    u = st(SRC_D3);
                    5'd9:    u = ld(SRC_ZERO);
                    5'd10:   u = mk(OP_MAC, SRC_W, CF_B2, 1'b1);
                    5'd11:   u = st(SRC_D4);
                    5'd12:   u = ld(SRC_D2);
                    5'd13:   u = mk(OP_MAC, SRC_W, CF_A1, 1'b0);
                    5'd14:   u = st(SRC_D1);
                    5'd15:   u = ld(SRC_ZERO);
                    5'd16:   u = mk(OP_MAC, SRC_W, CF_A2, 1'b0);
                    5'd17:   u = st(SRC_D2);
                    default: u = mk(OP_END, SRC_ZERO, CF_A0, 1'b0);
                endcase
            end
            default:
            begin
                case (pc)
                    5'd0:    u = ld(SRC_ZERO);
                    5'd1:    u = mk(OP_MAC, SRC_X, CF_A0, 1'b0);
                    5'd2:    u = mk(OP_ADD, SRC_D1, CF_A0, 1'b0);
                    5'd3:    u = st(SRC_Y);
                    5'd4:    u = ld(SRC_D2);
                    5'd5:    u = mk(OP_MAC, SRC_X, CF_A1, 1'b0);
                    5'd6:    u = mk(OP_MAC, SRC_Y, CF_B1, 1'b1);
                    5'd7:    u = st(SRC_D1);
                    5'd8:    u = ld(SRC_ZERO);
                    5'd9:    u = mk(OP_MAC, SRC_X, CF_A2, 1'b0);
                    5'd10:   u = mk(OP_MAC, SRC_Y, CF_B2, 1'b1);
                    5'd11:   u = st(SRC_D2);
                    default: u = mk(OP_END, SRC_ZERO, CF_A0, 1'b0);
                endcase
            end
        endcase
        return u;
    endfunction

endpackage

[hdl/biquad_iir_four_forms.sv]
// Second-order IIR section with four selectable structures, digit-serial multiplier.
//
// One sample in, one saturated sample out, through the structure picked by form_select
// (direct, canonical, transposed direct, transposed canonical). A small sequencer walks a
// fixed step list per structure; all five products go through one 32 x 4 bit digit
// multiplier that consumes the coefficient four bits a cycle, most significant digit first.
// Each product runs through the digit steps (S_MUL), rounding (S_RND) and accumulation
// (S_ACC); every load, add and store is a single step. Transposed canonical has the
// shortest step list and transposed direct the longest. The result register frees the
// input side while a result waits; a new item stalls at its last step only if the
// previous result has not been taken. Coefficient and form writes are taken in any
// cycle and should be made while the block is idle.
module biquad_iir_four_forms
    import bqf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          clipped,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data
);

    localparam int NDIG   = (COEF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int CPAD   = NDIG * DIGIT_BITS;
    localparam int PROD_W = STATE_BITS + CPAD;
    localparam int CNT_W  = $clog2(NDIG);
    localparam int RND_SH = COEF_BITS - 2;
    localparam int PP_W   = STATE_BITS + DIGIT_BITS + 1;

    localparam int IN_SH   = (SAMPLE_BITS - 1 > STATE_FRAC) ? SAMPLE_BITS - 1 - STATE_FRAC : 0;
    localparam int IN_LSH  = (SAMPLE_BITS - 1 > STATE_FRAC) ? 0 : STATE_FRAC - SAMPLE_BITS + 1;
    localparam int OUT_SH  = (SAMPLE_BITS - 1 < STATE_FRAC) ? STATE_FRAC - SAMPLE_BITS + 1 : 0;
    localparam int OUT_LSH = (SAMPLE_BITS - 1 < STATE_FRAC) ? 0 : SAMPLE_BITS - 1 - STATE_FRAC;

    localparam longint IN_HALF_L  = (IN_SH > 0) ? (64'sd1 <<< (IN_SH - 1)) : 64'sd0;
    localparam longint OUT_HALF_L = (OUT_SH > 0) ? (64'sd1 <<< (OUT_SH - 1)) : 64'sd0;
    localparam longint OUT_HI_L   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint ST_HI_L    = (64'sd1 <<< (STATE_BITS - 1)) - 64'sd1;

    localparam logic signed [SUM_BITS-1:0] IN_HALF  = SUM_BITS'(IN_HALF_L);
    localparam logic signed [SUM_BITS-1:0] OUT_HALF = SUM_BITS'(OUT_HALF_L);
    localparam logic signed [SUM_BITS-1:0] OUT_HI   = SUM_BITS'(OUT_HI_L);
    localparam logic signed [SUM_BITS-1:0] OUT_LO   = -OUT_HI - SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] ST_HI    = SUM_BITS'(ST_HI_L);
    localparam logic signed [SUM_BITS-1:0] ST_LO    = -ST_HI - SUM_BITS'(1);
    localparam logic signed [PROD_W-1:0]   RND_HALF = PROD_W'(64'sd1 <<< (COEF_BITS - 3));
    localparam logic [COEF_BITS-1:0]       A0_RESET = COEF_BITS'(64'd1 << (COEF_BITS - 2));

    // control and filter state
    state_t                        state_reg, state_next;
    logic [PC_BITS-1:0]            pc_reg, pc_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [STATE_BITS-1:0]  d1_reg, d1_next;
    logic signed [STATE_BITS-1:0]  d2_reg, d2_next;
    logic signed [STATE_BITS-1:0]  d3_reg, d3_next;
    logic signed [STATE_BITS-1:0]  d4_reg, d4_next;
    logic signed [COEF_BITS-1:0]   a0_reg, a1_reg, a2_reg, b1_reg, b2_reg;
    form_t                         form_reg;

    // datapath
    logic signed [STATE_BITS-1:0]  x_reg, x_next;
    logic signed [STATE_BITS-1:0]  w_reg, w_next;
    logic signed [STATE_BITS-1:0]  y_reg, y_next;
    logic signed [STATE_BITS-1:0]  opnd_reg, opnd_next;
    logic [CPAD-1:0]               coef_sh_reg, coef_sh_next;
    logic signed [PROD_W-1:0]      acc_reg, acc_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic signed [SUM_BITS-1:0]    rnd_reg, rnd_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg, sample_out_next;
    logic                          clipped_reg, clipped_next;

    uop_t                          uop;
    logic                          out_free;
    logic signed [STATE_BITS-1:0]  src_val;
    logic signed [SUM_BITS-1:0]    src_ext;
    logic signed [COEF_BITS-1:0]   coef_sel;
    logic signed [STATE_BITS-1:0]  sum_sat;
    logic signed [SUM_BITS-1:0]    x_in_wide;
    logic signed [SUM_BITS-1:0]    y_out_wide;
    logic [DIGIT_BITS-1:0]         digit;
    logic signed [DIGIT_BITS:0]    digit_s;
    logic signed [PP_W-1:0]        pp;
    logic signed [PROD_W-1:0]      rnd_full;

    assign uop      = prog_step(form_reg, pc_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign x_in_wide  = ((SUM_BITS'(sample_in) <<< IN_LSH) + IN_HALF) >>> IN_SH;
    assign y_out_wide = ((SUM_BITS'(y_reg) <<< OUT_LSH) + OUT_HALF) >>> OUT_SH;

    // top digit of the coefficient is signed, the rest unsigned
    assign digit    = coef_sh_reg[CPAD-1 -: DIGIT_BITS];
    assign digit_s  = (cnt_reg == '0) ? {digit[DIGIT_BITS-1], digit} : {1'b0, digit};
    assign pp       = PP_W'(opnd_reg) * PP_W'(digit_s);
    assign rnd_full = (acc_reg + RND_HALF) >>> RND_SH;

    always_comb
    begin
        case (uop.src)
            SRC_X:   src_val = x_reg;
            SRC_W:   src_val = w_reg;
            SRC_Y:   src_val = y_reg;
            SRC_D1:  src_val = d1_reg;
            SRC_D2:  src_val = d2_reg;
            SRC_D3:  src_val = d3_reg;
            SRC_D4:  src_val = d4_reg;
            default: src_val = '0;
        endcase
    end

    assign src_ext = SUM_BITS'(src_val);

    always_comb
    begin
        case (uop.cf)
            CF_A0:   coef_sel = a0_reg;
            CF_A1:   coef_sel = a1_reg;
            CF_A2:   coef_sel = a2_reg;
            CF_B1:   coef_sel = b1_reg;
            CF_B2:   coef_sel = b2_reg;
            default: coef_sel = '0;
        endcase
    end

    always_comb
    begin
        if (sum_reg > ST_HI)
        begin
            sum_sat = ST_HI[STATE_BITS-1:0];
        end
        else if (sum_reg < ST_LO)
        begin
            sum_sat = ST_LO[STATE_BITS-1:0];
        end
        else
        begin
            sum_sat = sum_reg[STATE_BITS-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (uop.op)
                    OP_MAC:
                    begin
                        state_next = S_MUL;
                    end
                    OP_END:
                    begin
                        if (out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_EXEC;
                    end
                endcase
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_W'(NDIG - 1))
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_EXEC;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cfg_ready  = 1'b1;
        out_valid  = out_valid_reg;
        sample_out = sample_out_reg;
        clipped    = clipped_reg;
    end

    // datapath next values
    always_comb
    begin
        pc_next         = pc_reg;
        cnt_next        = cnt_reg;
        d1_next         = d1_reg;
        d2_next         = d2_reg;
        d3_next         = d3_reg;
        d4_next         = d4_reg;
        x_next          = x_reg;
        w_next          = w_reg;
        y_next          = y_reg;
        opnd_next       = opnd_reg;
        coef_sh_next    = coef_sh_reg;
        acc_next        = acc_reg;
        sum_next        = sum_reg;
        rnd_next        = rnd_reg;
        sample_out_next = sample_out_reg;
        clipped_next    = clipped_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next  = x_in_wide[STATE_BITS-1:0];
                    pc_next = '0;
                end
            end
            S_EXEC:
            begin
                case (uop.op)
                    OP_LOAD:
                    begin
                        sum_next = src_ext;
                        pc_next  = pc_reg + PC_BITS'(1);
                    end
                    OP_ADD:
                    begin
                        sum_next = sum_reg + src_ext;
                        pc_next  = pc_reg + PC_BITS'(1);
                    end
                    OP_STORE:
                    begin
                        case (uop.src)
                            SRC_W:   w_next  = sum_sat;
                            SRC_Y:   y_next  = sum_sat;
                            SRC_D1:  d1_next = sum_sat;
                            SRC_D2:  d2_next = sum_sat;
                            SRC_D3:  d3_next = sum_sat;
                            SRC_D4:  d4_next = sum_sat;
                            default: y_next  = y_reg;
                        endcase
                        pc_next = pc_reg + PC_BITS'(1);
                    end
                    OP_MAC:
                    begin
                        opnd_next    = src_val;
                        coef_sh_next = CPAD'(coef_sel);
                        acc_next     = '0;
                        cnt_next     = '0;
                    end
                    OP_END:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            if (y_out_wide > OUT_HI)
                            begin
                                sample_out_next = OUT_HI[SAMPLE_BITS-1:0];
                                clipped_next    = 1'b1;
                            end
                            else if (y_out_wide < OUT_LO)
                            begin
                                sample_out_next = OUT_LO[SAMPLE_BITS-1:0];
                                clipped_next    = 1'b1;
                            end
                            else
                            begin
                                sample_out_next = y_out_wide[SAMPLE_BITS-1:0];
                                clipped_next    = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        pc_next = pc_reg;
                    end
                endcase
            end
            S_MUL:
            begin
                acc_next     = (acc_reg <<< DIGIT_BITS) + PROD_W'(pp);
                coef_sh_next = coef_sh_reg << DIGIT_BITS;
                cnt_next     = cnt_reg + CNT_W'(1);
            end
            S_RND:
            begin
                rnd_next = rnd_full[SUM_BITS-1:0];
            end
            S_ACC:
            begin
                sum_next = uop.neg ? (sum_reg - rnd_reg) : (sum_reg + rnd_reg);
                pc_next  = pc_reg + PC_BITS'(1);
            end
            default:
            begin
                pc_next = pc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            d1_reg        <= '0;
            d2_reg        <= '0;
            d3_reg        <= '0;
            d4_reg        <= '0;
            a0_reg        <= A0_RESET;
            a1_reg        <= '0;
            a2_reg        <= '0;
            b1_reg        <= '0;
            b2_reg        <= '0;
            form_reg      <= FORM_DIRECT;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            d3_reg        <= d3_next;
            d4_reg        <= d4_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_A0:   a0_reg   <= cfg_data;
                    REG_A1:   a1_reg   <= cfg_data;
                    REG_A2:   a2_reg   <= cfg_data;
                    REG_B1:   b1_reg   <= cfg_data;
                    REG_B2:   b2_reg   <= cfg_data;
                    REG_FORM: form_reg <= form_t'(cfg_data[FORM_BITS-1:0]);
                    default:  form_reg <= form_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        w_reg          <= w_next;
        y_reg          <= y_next;
        opnd_reg       <= opnd_next;
        coef_sh_reg    <= coef_sh_next;
        acc_reg        <= acc_next;
        sum_reg        <= sum_next;
        rnd_reg        <= rnd_next;
        sample_out_reg <= sample_out_next;
        clipped_reg    <= clipped_next;
    end

endmodule

[verif/biquad_iir_four_forms_tb.sv]
// Self-checking testbench for the biquad section: all four structures, saturation, stalls.
`timescale 1ns / 1ps

module biquad_iir_four_forms_tb;

    import bqf_pkg::*;

    // indexes past the last register, writes there must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam int  RANDOM_ITEMS = 1950;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  DRAIN_CYCLES = 80;
    localparam longint Q824_MAX  = 64'sd2147483647;
    localparam longint Q824_MIN  = -64'sd2147483648;
    localparam longint OUT_MAX   = 64'sd8388607;
    localparam longint OUT_MIN   = -64'sd8388608;

    typedef struct {
        logic signed [23:0] sample;
        logic               clip;
    } filt_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [23:0] sample_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [23:0] sample_out;
    logic               clipped;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_data = '0;

    // filter model: coefficients, structure and the four Q8.24 delay words
    logic signed [23:0] cf_a0, cf_a1, cf_a2, cf_b1, cf_b2;
    form_t              cur_form;
    longint             dl_one, dl_two, dl_three, dl_four;

    logic signed [23:0] samples_to_send[$];
    filt_result_t       filtered_q[$];
    filt_result_t       next_out;

    bit          idle_on = 1'b0;
    int          in_wait = 0;
    int          out_stall = 0;
    int          hold_left = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int unsigned fail_count = 0;
    int unsigned n_results = 0;
    int unsigned n_clipped = 0;
    int unsigned n_settings = 0;
    int unsigned form_items[4] = '{0, 0, 0, 0};

    biquad_iir_four_forms u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint sat_q824(longint v);
        if (v > Q824_MAX)
            return Q824_MAX;
        if (v < Q824_MIN)
            return Q824_MIN;
        return v;
    endfunction

    // Q2.22 times Q8.24, rounded half up back to Q8.24
    function automatic longint coef_mul(logic signed [23:0] c, longint v);
        return (longint'(c) * v + (longint'(1) <<< 21)) >>> 22;
    endfunction

    function automatic void filter_sample(input logic signed [23:0] s,
                                          output filt_result_t res);
        longint x, w, y, yr;
        x = sat_q824(longint'(s) * 2);
        y = 0;
        case (cur_form)
            FORM_DIRECT:
            begin
                y = sat_q824(coef_mul(cf_a0, x) + coef_mul(cf_a1, dl_one)
                             + coef_mul(cf_a2, dl_two) - coef_mul(cf_b1, dl_three)
                             - coef_mul(cf_b2, dl_four));
                dl_two   = dl_one;
                dl_one   = x;
                dl_four  = dl_three;
                dl_three = y;
            end
            FORM_CANONICAL:
            begin
                w = sat_q824(x - coef_mul(cf_b1, dl_one) - coef_mul(cf_b2, dl_two));
                y = sat_q824(coef_mul(cf_a0, w) + coef_mul(cf_a1, dl_one)
                             + coef_mul(cf_a2, dl_two));
                dl_two = dl_one;
                dl_one = w;
            end
            FORM_TDIRECT:
            begin
                w = sat_q824(x + dl_three);
                y = sat_q824(coef_mul(cf_a0, w) + dl_one);
                dl_three = sat_q824(dl_four - coef_mul(cf_b1, w));
                dl_four  = sat_q824(-coef_mul(cf_b2, w));
                dl_one   = sat_q824(dl_two + coef_mul(cf_a1, w));
                dl_two   = sat_q824(coef_mul(cf_a2, w));
            end
            default:
            begin
                y = sat_q824(coef_mul(cf_a0, x) + dl_one);
                dl_one = sat_q824(coef_mul(cf_a1, x) - coef_mul(cf_b1, y) + dl_two);
                dl_two = sat_q824(coef_mul(cf_a2, x) - coef_mul(cf_b2, y));
            end
        endcase
        yr = (y + 1) >>> 1;
        res.clip = 1'b0;
        if (yr > OUT_MAX)
        begin
            yr = OUT_MAX;
            res.clip = 1'b1;
        end
        else if (yr < OUT_MIN)
        begin
            yr = OUT_MIN;
            res.clip = 1'b1;
        end
        res.sample = yr[23:0];
    endfunction

    // kind 0: tame filter, 1: anything, 2: corner values
    function automatic logic [23:0] pick_coef(int kind, bit feedback);
        int lim;
        int t;
        logic [23:0] v;
        v = 24'($urandom);
        if (kind == 0)
        begin
            lim = feedback ? (1 << 20) : (1 << 22);
            t = int'($urandom_range(0, 2 * lim)) - lim;
            v = t[23:0];
        end
        else if (kind == 2)
        begin
            case ($urandom_range(0, 4))
                0:       v = 24'h800000;
                1:       v = 24'h7FFFFF;
                2:       v = 24'h000000;
                3:       v = 24'h400000;
                default: v = 24'hC00000;
            endcase
        end
        return v;
    endfunction

    function automatic logic signed [23:0] draw_sample();
        int pick;
        int t;
        logic signed [23:0] v;
        pick = $urandom_range(0, 99);
        v = 24'($urandom);
        if (pick >= 85)
        begin
            case ($urandom_range(0, 4))
                0:       v = 24'sh7FFFFF;
                1:       v = 24'sh800000;
                2:       v = 24'sh000000;
                3:       v = 24'shFFFFFF;
                default: v = 24'sh000001;
            endcase
        end
        else if (pick >= 70)
        begin
            t = int'($urandom_range(0, 2000)) - 1000;
            v = t[23:0];
        end
        return v;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_A0:   cf_a0 = val;
            REG_A1:   cf_a1 = val;
            REG_A2:   cf_a2 = val;
            REG_B1:   cf_b1 = val;
            REG_B2:   cf_b2 = val;
            REG_FORM: cur_form = form_t'(val[1:0]);
            default:  ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_coefs(input logic [23:0] a0, input logic [23:0] a1,
                               input logic [23:0] a2, input logic [23:0] b1,
                               input logic [23:0] b2);
        write_reg(REG_A0, a0);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || in_valid || filtered_q.size() != 0);
    endtask

    // sender: one item at a time from the queue, random gap after each while idle_on is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
            in_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                filter_sample(sample_in, next_out);
                filtered_q.push_back(next_out);
                form_items[cur_form]++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_wait != 0)
                begin
                    in_wait--;
                    in_valid <= 1'b0;
                end
                else if (samples_to_send.size() != 0)
                begin
                    sample_in <= samples_to_send.pop_front();
                    in_valid  <= 1'b1;
                    in_wait = idle_on ? $urandom_range(0, 8) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result, stalls at random while idle_on is set, long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("sample_out: item with nothing expected, got %0d", sample_out);
                    fail_count++;
                end
                else
                begin
                    next_out = filtered_q.pop_front();
                    if (sample_out !== next_out.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d", next_out.sample, sample_out);
                        fail_count++;
                    end
                    if (clipped !== next_out.clip)
                    begin
                        $error("clipped: expected %0b, got %0b", next_out.clip, clipped);
                        fail_count++;
                    end
                    n_results++;
                    if (next_out.clip)
                        n_clipped++;
                end
                out_stall = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (out_stall != 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int sent;
        int len;
        int kind;
        int n_phase;
        bit hold_phase;
        logic signed [23:0] corner[4];

        cf_a0    = 24'sh400000;
        cf_a1    = '0;
        cf_a2    = '0;
        cf_b1    = '0;
        cf_b2    = '0;
        cur_form = FORM_DIRECT;
        dl_one   = 0;
        dl_two   = 0;
        dl_three = 0;
        dl_four  = 0;
        corner   = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000};
        sent     = 0;
        n_phase  = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: unity pass-through
        samples_to_send = '{24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'sh000001,
                            24'shFFFFFF, 24'sh400000};
        wait_drained();
        n_settings++;

        // extreme coefficients: output clipping and saturated delay words in every form
        write_coefs(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        write_reg(REG_SPARE_LO, 24'h123456);
        write_reg(REG_SPARE_HI, 24'hFFFFFF);
        for (int f = 0; f < 4; f++)
        begin
            write_reg(REG_FORM, {22'h3FFFFF, 2'(f)});
            @(negedge clk);
            foreach (corner[i])
                samples_to_send.push_back(corner[i]);
            wait_drained();
            n_settings++;
        end

        while (sent < RANDOM_ITEMS)
        begin
            n_phase++;
            kind = $urandom_range(0, 99);
            kind = (kind < 60) ? 0 : ((kind < 85) ? 1 : 2);
            // sometimes only switch structure, keeping whatever the delays hold
            if ($urandom_range(0, 3) != 0)
                write_coefs(pick_coef(kind, 1'b0), pick_coef(kind, 1'b0),
                            pick_coef(kind, 1'b0), pick_coef(kind, 1'b1),
                            pick_coef(kind, 1'b1));
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
            write_reg(REG_FORM, 24'($urandom));
            n_settings++;

            hold_phase = (n_phase % 8 == 1);
            len = hold_phase ? 60 : $urandom_range(20, 120);
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            @(negedge clk);
            idle_on = hold_phase ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++)
                samples_to_send.push_back(draw_sample());
            if (hold_phase)
                hold_req++;
            sent += len;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d filtered samples (%0d clipped) over %0d register settings.",
                 n_results, n_clipped, n_settings);
        $display("Items per structure: direct %0d, canonical %0d, tdirect %0d, tcanonical %0d.",
                 form_items[0], form_items[1], form_items[2], form_items[3]);
        if (fail_count == 0 && filtered_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d items unsent and %0d results outstanding.",
                 samples_to_send.size(), filtered_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
